// ----- hdl/rrds_pkg.sv -----
// shared types and constants for the round-robin delay scheduler
// no dependencies
package rrds_pkg;

    localparam int IDX_W  = 5;
    localparam int TICK_W = 32;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_DELAY  = 2'd1;
    localparam logic [1:0] FUNC_SWITCH = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [TICK_W-1:0] delay_ticks;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  running_task;
        logic              switch_request;
        logic [TICK_W-1:0] tick_now;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [TICK_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } ctrl_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_RD,
        ST_TICK_LAST,
        ST_SWITCH,
        ST_FINISH
    } state_t;

endpackage

// ----- hdl/round_robin_delay_scheduler.sv -----
// round-robin delay scheduler, top level with result register
// throughput: one event at a time, set by the walk over the wake time memory
// and the ready flags, one task per cycle
// reset: all tasks ready, tick count zero, task one running
// depends on rrds_pkg, rrds_ctrl, rrds_wake_mem
module round_robin_delay_scheduler
    import rrds_pkg::*;
#(
    parameter int TASK_COUNT = 5
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    ctrl_status_t      status;
    result_t           ctrl_result;
    mem_req_t          mem_req;
    logic [TICK_W-1:0] rdata;
    logic              out_free;
    logic              valid_reg;
    result_t           result_reg;

    assign out_free   = !valid_reg || !result_stall;
    assign item_stall = !status.idle;

    rrds_ctrl #(
        .TASK_COUNT (TASK_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (item_valid && status.idle),
        .item     (item),
        .out_free (out_free),
        .status   (status),
        .result   (ctrl_result),
        .mem_req  (mem_req),
        .rdata    (rdata)
    );

    rrds_wake_mem #(
        .DEPTH (TASK_COUNT)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (status.res_valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.res_valid)
        begin
            result_reg <= ctrl_result;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ----- hdl/rrds_wake_mem.sv -----
// wake time memory, one write port and one registered read port
// depends on rrds_pkg
module rrds_wake_mem
    import rrds_pkg::*;
#(
    parameter int DEPTH = 5
)
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [TICK_W-1:0] rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [TICK_W-1:0] mem [DEPTH];
    logic [TICK_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/rrds_ctrl.sv -----
// event sequencer: ready flags, tick count, current task, table walks
// depends on rrds_pkg and the wake time memory read data
module rrds_ctrl
    import rrds_pkg::*;
#(
    parameter int TASK_COUNT = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  item_t             item,
    input  logic              out_free,
    output ctrl_status_t      status,
    output result_t           result,
    output mem_req_t          mem_req,
    input  logic [TICK_W-1:0] rdata
);

    localparam int IW = $clog2(TASK_COUNT);
    localparam int SW = $clog2(TASK_COUNT + 1);

    state_t            state_reg, state_next;
    logic [TASK_COUNT-1:0] rdy_reg, rdy_next;
    logic [TICK_W-1:0] count_reg, count_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [SW-1:0]     step_reg, step_next;
    logic              req_reg, req_next;
    logic [IW-1:0]     cur_inc;
    logic [IW-1:0]     idx_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rdy_reg       <= '1;
            count_reg     <= '0;
            cur_reg       <= IW'(1);
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rdy_reg       <= rdy_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        step_reg    <= step_next;
        req_reg     <= req_next;
    end

    assign cur_inc = (cur_reg == IW'(TASK_COUNT - 1)) ? '0 : cur_reg + 1'b1;
    assign idx_inc = (idx_reg == IW'(TASK_COUNT - 1)) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        rdy_next       = rdy_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = 1'b0;
        step_next      = step_reg;
        req_next       = req_reg;
        mem_req        = '0;
        status.idle      = 1'b0;
        status.res_valid = 1'b0;

        // wake check of the entry read in the previous cycle
        if (cmp_valid_reg && !rdy_reg[cmp_idx_reg] && rdata == count_reg)
        begin
            rdy_next[cmp_idx_reg] = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                status.idle = 1'b1;
                if (start)
                begin
                    req_next = 1'b0;
                    case (item.func)
                        FUNC_TICK:
                        begin
                            count_next = count_reg + 1'b1;
                            idx_next   = IW'(1);
                            req_next   = 1'b1;
                            state_next = ST_TICK_RD;
                        end
                        FUNC_DELAY:
                        begin
                            if (cur_reg != '0)
                            begin
                                mem_req.we        = 1'b1;
                                mem_req.waddr     = IDX_W'(cur_reg);
                                mem_req.wdata     = count_reg + item.delay_ticks;
                                rdy_next[cur_reg] = 1'b0;
                                req_next          = 1'b1;
                            end
                            state_next = ST_FINISH;
                        end
                        FUNC_SWITCH:
                        begin
                            idx_next   = cur_inc;
                            step_next  = SW'(1);
                            state_next = ST_SWITCH;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_TICK_RD:
            begin
                mem_req.re     = 1'b1;
                mem_req.raddr  = IDX_W'(idx_reg);
                cmp_valid_next = 1'b1;
                cmp_idx_next   = idx_reg;
                if (idx_reg == IW'(TASK_COUNT - 1))
                begin
                    state_next = ST_TICK_LAST;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            ST_TICK_LAST:
            begin
                state_next = ST_FINISH;
            end
            ST_SWITCH:
            begin
                if (idx_reg != '0 && rdy_reg[idx_reg])
                begin
                    cur_next   = idx_reg;
                    state_next = ST_FINISH;
                end
                else if (step_reg == SW'(TASK_COUNT))
                begin
                    cur_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next  = idx_inc;
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    status.res_valid = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result.running_task   = IDX_W'(cur_reg);
    assign result.switch_request = req_reg;
    assign result.tick_now       = count_reg;

endmodule
